>>> src/imt_pkg.sv
// Shared types, codes and constants of the interval mode table.
package imt_pkg;

	// Parameter line: ONE_VAL stands for 1.0
	localparam int FRAC_BITS = 16;
	localparam int VAL_W     = FRAC_BITS + 1;
	localparam int TOL_W     = 12;
	localparam int MODE_W    = 3;
	localparam int KIND_W    = 2;

	localparam logic [VAL_W-1:0] ONE_VAL   = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [TOL_W-1:0] TOL_RESET = 12'd66;

	// Operation codes
	localparam logic [MODE_W-1:0] MODE_ADD     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_VISIBLE = 3'd2;
	localparam logic [MODE_W-1:0] MODE_BARRIER = 3'd3;
	localparam logic [MODE_W-1:0] MODE_HIDDEN  = 3'd4;

	localparam logic [KIND_W-1:0] KIND_HIDDEN = 2'd0;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [VAL_W-1:0]  range_lo;
		logic [VAL_W-1:0]  range_hi;
		logic [KIND_W-1:0] line_kind;
	} op_t;

	typedef struct packed {
		logic [VAL_W-1:0] out_lo;
		logic [VAL_W-1:0] out_hi;
		logic             range_valid;
		logic             is_covered;
		logic             table_full;
		logic             last_item;
	} res_t;

	typedef struct packed {
		logic [VAL_W-1:0]  lo;
		logic [VAL_W-1:0]  hi;
		logic [KIND_W-1:0] kind;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISP,
		ST_P1_RD,
		ST_P1_EX,
		ST_INS,
		ST_P2_RD,
		ST_P2_EX,
		ST_FLUSH,
		ST_COMMIT,
		ST_Q_RD,
		ST_Q_EX,
		ST_FIN_U,
		ST_FIN_G,
		ST_FIN_P
	} state_t;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_START,
		ACT_P1,
		ACT_INS,
		ACT_P2,
		ACT_FLUSH,
		ACT_COMMIT,
		ACT_Q,
		ACT_FIN_U,
		ACT_FIN_G,
		ACT_FIN_P
	} act_t;

	typedef struct packed {
		act_t act;
		logic fire;
	} cmd_t;

	typedef struct packed {
		logic is_edit;
		logic is_query;
		logic is_test_scan;
		logic has_entries;
		logic cut;
		logic idx_end;
		logic push_need;
		logic out_free;
	} stat_t;

endpackage

>>> src/imt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module imt_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

>>> src/imt_dp.sv
// Datapath: table banks, cut and merge logic, union and gap logic, result register.
module imt_dp #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  imt_pkg::cmd_t                   cmd,
	output imt_pkg::stat_t                  st,
	input  imt_pkg::op_t                    op_data,
	input  logic                            cfg_valid,
	input  logic [imt_pkg::TOL_W-1:0]       cfg_data,
	input  logic                            res_stall,
	output logic                            res_valid,
	output imt_pkg::res_t                   res_data
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int V  = imt_pkg::VAL_W;
	localparam int S  = V + 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	// Control registers
	logic [imt_pkg::TOL_W-1:0] tol_q;
	logic                      bank_q;
	logic [CW-1:0]             count_q;
	logic [AW-1:0]             idx_q;
	logic [CW-1:0]             widx_q;
	logic                      ovf_q;
	logic                      m_have_q;
	logic                      u_have_q;
	logic                      pend_v_q;
	logic                      cov_q;
	logic                      out_v_q;

	// Payload registers
	imt_pkg::op_t   op_q;
	imt_pkg::entry_t m_cur_q;
	logic [V-1:0]   ulo_q;
	logic [V-1:0]   uhi_q;
	logic [V-1:0]   last_q;
	logic [V-1:0]   pend_lo_q;
	logic [V-1:0]   pend_hi_q;
	imt_pkg::res_t  out_q;

	// Combinational
	imt_pkg::entry_t e;
	imt_pkg::entry_t item;
	imt_pkg::op_t    op_sat;
	imt_pkg::res_t   out_d;
	logic [$bits(imt_pkg::entry_t)-1:0] rd_data;
	logic [V-1:0] lo, hi, tlo, thi, d_abs, new_last, em_lo, em_hi;
	logic [S-1:0] tol_s;
	logic [V-1:0] tol_v;
	logic is_edit, is_insert, is_visible, is_barrier, is_query, is_test, hidden_only, cut;
	logic e_below, e_above, b_keep, c_keep, item_v, m_join, m_write, ram_we;
	logic uv, sep, fin_en, fin_emit, fin_cov, g_emit, emit_v, out_load, idx_end, scan_act;

	// Decode the held operation
	assign lo          = op_q.range_lo;
	assign hi          = op_q.range_hi;
	assign is_edit     = (op_q.mode == imt_pkg::MODE_ADD) || (op_q.mode == imt_pkg::MODE_REMOVE);
	assign is_insert   = (op_q.mode == imt_pkg::MODE_ADD);
	assign is_visible  = (op_q.mode == imt_pkg::MODE_VISIBLE);
	assign is_barrier  = (op_q.mode == imt_pkg::MODE_BARRIER);
	assign is_query    = is_visible || is_barrier;
	assign is_test     = (op_q.mode == imt_pkg::MODE_HIDDEN);
	assign hidden_only = is_barrier || is_test;
	assign cut         = hi > lo;
	assign tlo         = (lo < hi) ? lo : hi;
	assign thi         = (lo < hi) ? hi : lo;
	assign tol_s       = S'(tol_q);
	assign tol_v       = V'(tol_q);
	assign e           = imt_pkg::entry_t'(rd_data);

	// Saturate incoming range ends to 1.0
	always_comb begin
		op_sat = op_data;
		if (op_data.range_lo > imt_pkg::ONE_VAL) begin
			op_sat.range_lo = imt_pkg::ONE_VAL;
		end
		if (op_data.range_hi > imt_pkg::ONE_VAL) begin
			op_sat.range_hi = imt_pkg::ONE_VAL;
		end
	end

	// Cut tests against the current table entry
	assign e_below = e.hi <= lo;
	assign e_above = e.lo >= hi;
	assign b_keep  = ({1'b0, e.lo} + tol_s) < {1'b0, lo};
	assign c_keep  = {1'b0, e.hi} > ({1'b0, hi} + tol_s);

	// Pick the item that enters the merge
	always_comb begin
		item_v = 1'b0;
		item   = e;
		case (cmd.act)
			imt_pkg::ACT_P1: begin
				if (!cut || e_below) begin
					item_v = 1'b1;
				end else if (!e_above) begin
					item_v  = b_keep;
					item.hi = lo;
				end
			end
			imt_pkg::ACT_P2: begin
				if (e_above) begin
					item_v = 1'b1;
				end else if (!e_below) begin
					item_v  = c_keep;
					item.lo = hi;
				end
			end
			imt_pkg::ACT_INS: begin
				item_v    = is_insert && cut;
				item.lo   = lo;
				item.hi   = hi;
				item.kind = op_q.line_kind;
			end
			default: begin
			end
		endcase
	end

	// Same-kind merge and write into the spare bank
	assign m_join  = m_have_q && (item.kind == m_cur_q.kind)
		&& ({1'b0, item.lo} <= ({1'b0, m_cur_q.hi} + tol_s));
	assign m_write = cmd.fire && m_have_q
		&& ((item_v && !m_join) || (cmd.act == imt_pkg::ACT_FLUSH));
	assign ram_we  = m_write && !ovf_q && (widx_q != DEPTH_C);

	imt_ram #(
		.WIDTH($bits(imt_pkg::entry_t)),
		.DEPTH(2 << AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr ({~bank_q, widx_q[AW-1:0]}),
		.wdata (m_cur_q),
		.raddr ({bank_q, idx_q}),
		.rdata (rd_data)
	);

	// Union of table entries for the queries
	assign uv  = (cmd.act == imt_pkg::ACT_Q) && (!hidden_only || (e.kind == imt_pkg::KIND_HIDDEN));
	assign sep = (uhi_q < e.lo) && ((e.lo - uhi_q) >= tol_v);
	assign fin_en = ((cmd.act == imt_pkg::ACT_Q) && uv && u_have_q && sep)
		|| ((cmd.act == imt_pkg::ACT_FIN_U) && u_have_q);

	// Close one union segment: gap before it, or containment
	always_comb begin
		d_abs    = (last_q > ulo_q) ? (last_q - ulo_q) : (ulo_q - last_q);
		fin_emit = 1'b0;
		new_last = uhi_q;
		if (is_visible) begin
			fin_emit = d_abs >= tol_v;
		end else if (is_barrier) begin
			fin_emit = {1'b0, ulo_q} > ({1'b0, last_q} + tol_s);
			new_last = (uhi_q > last_q) ? uhi_q : last_q;
		end
		fin_cov = is_test && (({1'b0, tlo} + tol_s) >= {1'b0, ulo_q})
			&& ({1'b0, thi} <= ({1'b0, uhi_q} + tol_s));
		g_emit = is_visible ? ((imt_pkg::ONE_VAL - last_q) >= tol_v)
			: (({1'b0, last_q} + tol_s) < {1'b0, imt_pkg::ONE_VAL});
	end

	assign emit_v = (fin_en && fin_emit && is_query)
		|| ((cmd.act == imt_pkg::ACT_FIN_G) && g_emit);
	assign em_lo  = last_q;
	assign em_hi  = (cmd.act == imt_pkg::ACT_FIN_G) ? imt_pkg::ONE_VAL : ulo_q;

	// Result beat to load
	always_comb begin
		out_d = '0;
		out_d.last_item = 1'b1;
		if (cmd.act != imt_pkg::ACT_FIN_P) begin
			out_d.out_lo      = pend_lo_q;
			out_d.out_hi      = pend_hi_q;
			out_d.range_valid = 1'b1;
			out_d.last_item   = 1'b0;
		end else if (is_edit) begin
			out_d.table_full = ovf_q;
		end else if (is_query && pend_v_q) begin
			out_d.out_lo      = pend_lo_q;
			out_d.out_hi      = pend_hi_q;
			out_d.range_valid = 1'b1;
		end else if (is_test) begin
			out_d.is_covered = cov_q;
		end
	end

	assign out_load = cmd.fire
		&& ((emit_v && pend_v_q) || (cmd.act == imt_pkg::ACT_FIN_P));
	assign scan_act = (cmd.act == imt_pkg::ACT_P1) || (cmd.act == imt_pkg::ACT_P2)
		|| (cmd.act == imt_pkg::ACT_Q);
	assign idx_end  = (CW'(idx_q) == (count_q - CW'(1)));

	// Status to the controller
	assign st.is_edit      = is_edit;
	assign st.is_query     = is_query;
	assign st.is_test_scan = is_test && (lo != hi);
	assign st.has_entries  = count_q != '0;
	assign st.cut          = cut;
	assign st.idx_end      = idx_end;
	assign st.push_need    = (emit_v && pend_v_q) || (cmd.act == imt_pkg::ACT_FIN_P);
	assign st.out_free     = !out_v_q || !res_stall;

	assign res_valid = out_v_q;
	assign res_data  = out_q;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q    <= imt_pkg::TOL_RESET;
			bank_q   <= 1'b0;
			count_q  <= '0;
			idx_q    <= '0;
			widx_q   <= '0;
			ovf_q    <= 1'b0;
			m_have_q <= 1'b0;
			u_have_q <= 1'b0;
			pend_v_q <= 1'b0;
			cov_q    <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				tol_q <= cfg_data;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (!res_stall) begin
				out_v_q <= 1'b0;
			end
			if (cmd.fire) begin
				if (cmd.act == imt_pkg::ACT_START) begin
					idx_q    <= '0;
					widx_q   <= '0;
					ovf_q    <= 1'b0;
					m_have_q <= 1'b0;
					u_have_q <= 1'b0;
					pend_v_q <= 1'b0;
					cov_q    <= 1'b0;
				end
				if (scan_act) begin
					idx_q <= idx_end ? '0 : idx_q + AW'(1);
				end
				if (item_v) begin
					m_have_q <= 1'b1;
				end
				if (m_write) begin
					if (widx_q == DEPTH_C) begin
						ovf_q <= 1'b1;
					end else begin
						widx_q <= widx_q + CW'(1);
					end
				end
				if (cmd.act == imt_pkg::ACT_COMMIT && !ovf_q) begin
					bank_q  <= ~bank_q;
					count_q <= widx_q;
				end
				if (uv) begin
					u_have_q <= 1'b1;
				end
				if (emit_v) begin
					pend_v_q <= 1'b1;
				end
				if (fin_en && fin_cov) begin
					cov_q <= 1'b1;
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_d;
		end
		if (cmd.fire) begin
			if (cmd.act == imt_pkg::ACT_START) begin
				op_q   <= op_sat;
				last_q <= '0;
			end
			if (item_v) begin
				if (!m_have_q || !m_join) begin
					m_cur_q <= item;
				end else if (item.hi > m_cur_q.hi) begin
					m_cur_q.hi <= item.hi;
				end
			end
			if (uv) begin
				if (!u_have_q || sep) begin
					ulo_q <= e.lo;
					uhi_q <= e.hi;
				end else if (e.hi > uhi_q) begin
					uhi_q <= e.hi;
				end
			end
			if (fin_en) begin
				last_q <= new_last;
			end
			if (emit_v) begin
				pend_lo_q <= em_lo;
				pend_hi_q <= em_hi;
			end
		end
	end

	// A result beat never lands on one that is still stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_v_q || !res_stall))
		else $error("result beat overwritten");

	// Entry count stays within the table
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count beyond table depth");

	// An overflowing edit leaves the table as it was
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fire && (cmd.act == imt_pkg::ACT_COMMIT) && ovf_q)
		|=> ($stable(count_q) && $stable(bank_q)))
		else $error("overflowing edit changed the table");

endmodule

>>> src/imt_ctrl.sv
// Controller state machine that sequences the table passes.
module imt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           op_valid,
	output logic           op_stall,
	input  imt_pkg::stat_t st,
	output imt_pkg::cmd_t  cmd
);

	imt_pkg::state_t state_q;
	imt_pkg::state_t state_d;
	logic            go;

	// Hold a step while its result beat has no room
	assign go       = !st.push_need || st.out_free;
	assign op_stall = state_q != imt_pkg::ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= imt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and command
	always_comb begin
		state_d  = state_q;
		cmd.act  = imt_pkg::ACT_NONE;
		cmd.fire = 1'b0;
		case (state_q)
			imt_pkg::ST_IDLE: begin
				cmd.act  = imt_pkg::ACT_START;
				cmd.fire = op_valid;
				if (op_valid) begin
					state_d = imt_pkg::ST_DISP;
				end
			end
			imt_pkg::ST_DISP: begin
				if (st.is_edit) begin
					state_d = st.has_entries ? imt_pkg::ST_P1_RD : imt_pkg::ST_INS;
				end else if (st.is_query) begin
					state_d = st.has_entries ? imt_pkg::ST_Q_RD : imt_pkg::ST_FIN_U;
				end else if (st.is_test_scan && st.has_entries) begin
					state_d = imt_pkg::ST_Q_RD;
				end else begin
					state_d = imt_pkg::ST_FIN_P;
				end
			end
			imt_pkg::ST_P1_RD: begin
				state_d = imt_pkg::ST_P1_EX;
			end
			imt_pkg::ST_P1_EX: begin
				cmd.act  = imt_pkg::ACT_P1;
				cmd.fire = 1'b1;
				state_d  = st.idx_end ? imt_pkg::ST_INS : imt_pkg::ST_P1_RD;
			end
			imt_pkg::ST_INS: begin
				cmd.act  = imt_pkg::ACT_INS;
				cmd.fire = 1'b1;
				state_d  = (st.cut && st.has_entries) ? imt_pkg::ST_P2_RD : imt_pkg::ST_FLUSH;
			end
			imt_pkg::ST_P2_RD: begin
				state_d = imt_pkg::ST_P2_EX;
			end
			imt_pkg::ST_P2_EX: begin
				cmd.act  = imt_pkg::ACT_P2;
				cmd.fire = 1'b1;
				state_d  = st.idx_end ? imt_pkg::ST_FLUSH : imt_pkg::ST_P2_RD;
			end
			imt_pkg::ST_FLUSH: begin
				cmd.act  = imt_pkg::ACT_FLUSH;
				cmd.fire = 1'b1;
				state_d  = imt_pkg::ST_COMMIT;
			end
			imt_pkg::ST_COMMIT: begin
				cmd.act  = imt_pkg::ACT_COMMIT;
				cmd.fire = 1'b1;
				state_d  = imt_pkg::ST_FIN_P;
			end
			imt_pkg::ST_Q_RD: begin
				state_d = imt_pkg::ST_Q_EX;
			end
			imt_pkg::ST_Q_EX: begin
				cmd.act  = imt_pkg::ACT_Q;
				cmd.fire = go;
				if (go) begin
					state_d = st.idx_end ? imt_pkg::ST_FIN_U : imt_pkg::ST_Q_RD;
				end
			end
			imt_pkg::ST_FIN_U: begin
				cmd.act  = imt_pkg::ACT_FIN_U;
				cmd.fire = go;
				if (go) begin
					state_d = st.is_query ? imt_pkg::ST_FIN_G : imt_pkg::ST_FIN_P;
				end
			end
			imt_pkg::ST_FIN_G: begin
				cmd.act  = imt_pkg::ACT_FIN_G;
				cmd.fire = go;
				if (go) begin
					state_d = imt_pkg::ST_FIN_P;
				end
			end
			imt_pkg::ST_FIN_P: begin
				cmd.act  = imt_pkg::ACT_FIN_P;
				cmd.fire = go;
				if (go) begin
					state_d = imt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = imt_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> src/interval_mode_table_top.sv
// Top level of the interval mode table: controller plus datapath.
//
// Keeps a sorted table of up to TABLE_DEPTH tagged intervals on the line 0..1.0
// (1.0 = 65536) in two banks of one RAM. Each operation takes one input beat and
// answers with one or more result beats, the final one marked by last_item.
// An add or remove reads the active bank twice (once if hi is not above lo),
// each stored entry read and then cut and merged, and streams the merged table
// into the spare bank, which becomes active unless the result would overflow.
// A query reads the bank once, through the single RAM read port, and is held
// while the result side stalls. A new operation is taken once the previous
// one has loaded its final beat into the output register. No clearing pass
// follows reset; the table starts empty.
module interval_mode_table_top #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      op_valid,
	output logic                      op_stall,
	input  imt_pkg::op_t              op_data,
	output logic                      res_valid,
	input  logic                      res_stall,
	output imt_pkg::res_t             res_data,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [imt_pkg::TOL_W-1:0] cfg_data
);

	imt_pkg::cmd_t  cmd;
	imt_pkg::stat_t st;

	// Tolerance writes are always taken
	assign cfg_ready = 1'b1;

	imt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op_stall (op_stall),
		.st       (st),
		.cmd      (cmd)
	);

	imt_dp #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.op_data   (op_data),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.res_data  (res_data)
	);

endmodule
